>>> rtl/cljq_pkg.sv
// shared types and constants for the cursor linked job queue
`timescale 1ns / 1ps
package cljq_pkg;
  localparam int unsigned SlotN  = 16;
  localparam int unsigned SlotW  = 4;
  localparam int unsigned CountW = 5;
  localparam int unsigned DataW  = 32;

  typedef enum logic [3:0] {
    MODE_APPEND = 4'd0,
    MODE_REMOVE = 4'd1,
    MODE_DELETE = 4'd2,
    MODE_NEXT   = 4'd3,
    MODE_PREV   = 4'd4,
    MODE_FIRST  = 4'd5,
    MODE_LAST   = 4'd6,
    MODE_READ   = 4'd7,
    MODE_WRITE  = 4'd8
  } mode_e;

  typedef struct packed {
    logic load;     // capture transaction, start link reads
    logic execute;  // apply the operation
  } cmd_t;
endpackage

>>> rtl/cljq_datapath.sv
// slot pool, link memories, free stack and result register
`timescale 1ns / 1ps
module cljq_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cljq_pkg::cmd_t                  cmd_i,
  input  logic [3:0]                      mode_i,
  input  logic [cljq_pkg::DataW-1:0]      word_i,
  input  logic [cljq_pkg::CountW-1:0]     capacity_i,
  output logic                            ok_o,
  output logic [cljq_pkg::DataW-1:0]      job_out_o,
  output logic [cljq_pkg::CountW-1:0]     count_o,
  output logic                            full_o,
  output logic                            empty_o
);
  localparam int unsigned SW = cljq_pkg::SlotW;
  localparam int unsigned CW = cljq_pkg::CountW;

  logic [cljq_pkg::DataW-1:0] pay_mem [cljq_pkg::SlotN];
  logic [SW-1:0] next_mem [cljq_pkg::SlotN];
  logic [SW-1:0] prev_mem [cljq_pkg::SlotN];
  logic [SW-1:0] free_mem [cljq_pkg::SlotN];

  logic [CW-1:0] free_top_q, count_q;
  logic [SW-1:0] head_q, tail_q, cursor_q;
  logic [3:0] mode_q;
  logic [cljq_pkg::DataW-1:0] word_q;
  // registered reads
  logic [SW-1:0] cur_next_q, cur_prev_q, head_next_q, free_slot_q;
  logic [cljq_pkg::DataW-1:0] cur_pay_q;
  logic sweep_q;
  logic [SW-1:0] sweep_ix_q;

  logic [CW-1:0] ucap;
  logic has, can_app;
  assign ucap    = (capacity_i > CW'(cljq_pkg::SlotN)) ? CW'(cljq_pkg::SlotN) : capacity_i;
  assign has     = count_q != '0;
  assign can_app = (count_q < ucap) && (free_top_q != '0);

  // reset fills the free stack over a sweep; free_top starts full and the
  // controller takes no input until the sweep ends, so no pop comes before it
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q      <= mode_i;
      word_q      <= word_i;
      cur_next_q  <= next_mem[cursor_q];
      cur_prev_q  <= prev_mem[cursor_q];
      head_next_q <= next_mem[head_q];
      cur_pay_q   <= pay_mem[cursor_q];
      free_slot_q <= free_mem[SW'(free_top_q - 1'b1)];
    end
  end

  logic rel;
  logic [SW-1:0] rel_slot;
  always_comb begin
    rel = 1'b0;
    rel_slot = cursor_q;
    if (cmd_i.execute && has) begin
      if (mode_q == cljq_pkg::MODE_REMOVE) begin
        rel = 1'b1;
        rel_slot = head_q;
      end else if (mode_q == cljq_pkg::MODE_DELETE) begin
        rel = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sweep_q) begin
      free_mem[sweep_ix_q] <= SW'(cljq_pkg::SlotN - 1) - sweep_ix_q;
    end else if (rel && free_top_q < CW'(cljq_pkg::SlotN)) begin
      free_mem[SW'(free_top_q)] <= rel_slot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q    <= 1'b1;
      sweep_ix_q <= '0;
    end else if (sweep_q) begin
      sweep_ix_q <= sweep_ix_q + 1'b1;
      if (sweep_ix_q == SW'(cljq_pkg::SlotN - 1)) sweep_q <= 1'b0;
    end
  end

  // link and payload writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      case (mode_q)
        cljq_pkg::MODE_APPEND: begin
          if (can_app) begin
            pay_mem[free_slot_q] <= word_q;
            if (!has) begin
              next_mem[free_slot_q] <= free_slot_q;
              prev_mem[free_slot_q] <= free_slot_q;
            end else begin
              prev_mem[free_slot_q] <= tail_q;
              next_mem[free_slot_q] <= head_q;
              prev_mem[head_q]      <= free_slot_q;
              next_mem[tail_q]      <= free_slot_q;
            end
          end
        end
        cljq_pkg::MODE_REMOVE: begin
          if (count_q > CW'(1)) begin
            prev_mem[head_next_q] <= tail_q;
            next_mem[tail_q]      <= head_next_q;
          end
        end
        cljq_pkg::MODE_DELETE: begin
          if (count_q > CW'(1)) begin
            prev_mem[cur_next_q] <= cur_prev_q;
            next_mem[cur_prev_q] <= cur_next_q;
          end
        end
        cljq_pkg::MODE_WRITE: begin
          if (has) pay_mem[cursor_q] <= word_q;
        end
        default: ;
      endcase
    end
  end

  logic ok_d;
  logic [cljq_pkg::DataW-1:0] rd_d;
  logic [CW-1:0] count_d, top_d;
  logic [SW-1:0] head_d, tail_d, cursor_d;
  always_comb begin
    ok_d = 1'b0; rd_d = '0;
    count_d = count_q; top_d = free_top_q;
    head_d = head_q; tail_d = tail_q; cursor_d = cursor_q;
    if (rel && free_top_q < CW'(cljq_pkg::SlotN)) top_d = free_top_q + 1'b1;
    case (mode_q)
      cljq_pkg::MODE_APPEND: if (can_app) begin
        ok_d = 1'b1; top_d = free_top_q - 1'b1;
        if (!has) head_d = free_slot_q;
        tail_d = free_slot_q; cursor_d = free_slot_q; count_d = count_q + 1'b1;
      end
      cljq_pkg::MODE_REMOVE: if (has) begin
        ok_d = 1'b1;
        if (count_q == CW'(1)) begin
          head_d = '0; tail_d = '0; cursor_d = '0; count_d = '0;
        end else begin
          head_d = head_next_q; cursor_d = head_next_q; count_d = count_q - 1'b1;
        end
      end
      cljq_pkg::MODE_DELETE: if (has) begin
        ok_d = 1'b1;
        if (count_q == CW'(1)) begin
          head_d = '0; tail_d = '0; cursor_d = '0; count_d = '0;
        end else begin
          if (cursor_q == head_q) head_d = cur_next_q;
          if (cursor_q == tail_q) tail_d = cur_prev_q;
          cursor_d = cur_next_q; count_d = count_q - 1'b1;
        end
      end
      cljq_pkg::MODE_NEXT:  if (has) begin ok_d = 1'b1; cursor_d = cur_next_q; end
      cljq_pkg::MODE_PREV:  if (has) begin ok_d = 1'b1; cursor_d = cur_prev_q; end
      cljq_pkg::MODE_FIRST: if (has) begin ok_d = 1'b1; cursor_d = head_q; end
      cljq_pkg::MODE_LAST:  if (has) begin ok_d = 1'b1; cursor_d = tail_q; end
      cljq_pkg::MODE_READ:  if (has) begin ok_d = 1'b1; rd_d = cur_pay_q; end
      cljq_pkg::MODE_WRITE: if (has) ok_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_top_q <= CW'(cljq_pkg::SlotN);
      count_q <= '0; head_q <= '0; tail_q <= '0; cursor_q <= '0;
    end else if (cmd_i.execute) begin
      free_top_q <= top_d; count_q <= count_d;
      head_q <= head_d; tail_q <= tail_d; cursor_q <= cursor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      ok_o      <= ok_d;
      job_out_o <= rd_d;
      count_o   <= count_d;
      full_o    <= count_d >= ucap;
      empty_o   <= count_d == '0;
    end
  end
endmodule

>>> rtl/cljq_ctrl.sv
// handshake controller for the cursor linked job queue
`timescale 1ns / 1ps
module cljq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output cljq_pkg::cmd_t cmd_o
);
  typedef enum logic [1:0] {ST_INIT, ST_IDLE, ST_EXEC} state_e;
  state_e state_q;
  logic [cljq_pkg::SlotW-1:0] init_q;
  logic out_valid_q;

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign cmd_o.load    = in_valid_i && in_ready_o;
  assign cmd_o.execute = state_q == ST_EXEC;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT; init_q <= '0; out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_INIT: begin
          init_q <= init_q + 1'b1;
          if (init_q == cljq_pkg::SlotW'(cljq_pkg::SlotN - 1)) state_q <= ST_IDLE;
        end
        ST_IDLE: if (cmd_o.load) state_q <= ST_EXEC;
        ST_EXEC: begin
          out_valid_q <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule

>>> rtl/cursor_linked_job_queue.sv
// top level of the cursor linked job queue
// result: tvalid is registered and rises after the exec state that follows
// the input transaction, once the result register has been written
// flow: the next transaction waits for the link read then write of the last
// one and for its result to be taken; reset: asynchronous active low; a free
// stack fill follows reset, during which no input is taken; capacity resets to 1
`timescale 1ns / 1ps
module cursor_linked_job_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // mode[3:0], job_word[35:4], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // ok, job_out, entry_count, is_full, is_empty
);
  logic [4:0] capacity_q;
  cljq_pkg::cmd_t cmd;
  logic ok, full, empty;
  logic [31:0] job_out;
  logic [4:0] count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) capacity_q <= 5'd1;
    else if (cfg_we_i) capacity_q <= cfg_wdata_i;
  end

  cljq_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .cmd_o(cmd)
  );

  cljq_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .mode_i(s_axis_tdata[3:0]), .word_i(s_axis_tdata[35:4]),
    .capacity_i(capacity_q),
    .ok_o(ok), .job_out_o(job_out), .count_o(count), .full_o(full), .empty_o(empty)
  );

  assign m_axis_tdata = {empty, full, count, job_out, ok};
endmodule

>>> rtl/cljq_checker.sv
// port level checks for the cursor linked job queue
`timescale 1ns / 1ps
module cljq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[39] == (m_axis_tdata[37:33] == 5'd0)))
    else $error("empty flag mismatch");
  a_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> m_axis_tdata[32:1] == 32'd0)
    else $error("refused result carries data");
  a_one_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> ##1 m_axis_tvalid)
    else $error("result missing");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("stalled result changed");
endmodule

bind cursor_linked_job_queue cljq_checker u_cljq_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

>>> sim/tb_cursor_linked_job_queue.sv
// self-checking testbench for the cursor linked job queue
`timescale 1ns / 1ps
module tb_cursor_linked_job_queue;

  typedef struct packed {
    logic        is_empty;
    logic        is_full;
    logic [4:0]  entry_count;
    logic [31:0] job_out;
    logic        ok;
  } resp_t;

  typedef struct {
    logic [3:0]  mode;
    logic [31:0] word;
  } job_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [4:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  cursor_linked_job_queue u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #10 clk_i = ~clk_i;

  // shadow list state
  logic [31:0] sh_pay [cljq_pkg::SlotN];
  logic [3:0]  sh_nxt [cljq_pkg::SlotN];
  logic [3:0]  sh_prv [cljq_pkg::SlotN];
  logic [3:0]  sh_free [cljq_pkg::SlotN];
  int          sh_ftop;
  logic [3:0]  sh_head, sh_tail, sh_cur;
  int          sh_cnt;
  int          sh_cap;

  job_req_t job_pending[$];
  resp_t    resp_expected[$];
  int       n_fail = 0;
  int       n_sent = 0;
  int       n_seen = 0;

  function automatic int eff_cap();
    return (sh_cap < cljq_pkg::SlotN) ? sh_cap : cljq_pkg::SlotN;
  endfunction

  function automatic resp_t list_step(logic [3:0] mode, logic [31:0] word);
    resp_t r;
    logic [3:0] s, nx, pv;
    r = '0;
    if (mode == cljq_pkg::MODE_APPEND) begin
      if (sh_cnt < eff_cap() && sh_ftop > 0) begin
        sh_ftop--;
        s = sh_free[sh_ftop];
        sh_pay[s] = word;
        if (sh_cnt == 0) begin
          sh_nxt[s] = s; sh_prv[s] = s; sh_head = s;
        end else begin
          sh_prv[s] = sh_tail; sh_nxt[s] = sh_head;
          sh_prv[sh_head] = s; sh_nxt[sh_tail] = s;
        end
        sh_tail = s; sh_cur = s; sh_cnt++; r.ok = 1;
      end
    end else if (sh_cnt != 0) begin
      r.ok = 1;
      case (mode)
        cljq_pkg::MODE_REMOVE, cljq_pkg::MODE_DELETE: begin
          s = (mode == cljq_pkg::MODE_REMOVE) ? sh_head : sh_cur;
          if (sh_cnt == 1) begin
            sh_head = 0; sh_tail = 0; sh_cur = 0; sh_cnt = 0;
          end else begin
            nx = sh_nxt[s]; pv = sh_prv[s];
            if (s == sh_head) sh_head = nx;
            if (s == sh_tail) sh_tail = pv;
            sh_prv[nx] = pv; sh_nxt[pv] = nx;
            sh_cur = nx; sh_cnt--;
          end
          if (sh_ftop < cljq_pkg::SlotN) begin
            sh_free[sh_ftop] = s; sh_ftop++;
          end
        end
        cljq_pkg::MODE_NEXT:  sh_cur = sh_nxt[sh_cur];
        cljq_pkg::MODE_PREV:  sh_cur = sh_prv[sh_cur];
        cljq_pkg::MODE_FIRST: sh_cur = sh_head;
        cljq_pkg::MODE_LAST:  sh_cur = sh_tail;
        cljq_pkg::MODE_READ:  r.job_out = sh_pay[sh_cur];
        cljq_pkg::MODE_WRITE: sh_pay[sh_cur] = word;
        default:    r.ok = 0;
      endcase
    end
    r.entry_count = sh_cnt[4:0];
    r.is_full = (sh_cnt >= eff_cap());
    r.is_empty = (sh_cnt == 0);
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // driver
  int   drv_gap = 0;
  logic s_axis_tready_q = 1'b0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready_q) begin
        if (drv_gap > 0) begin
          drv_gap <= drv_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (job_pending.size() > 0) begin
          job_req_t j;
          j = job_pending.pop_front();
          s_axis_tdata <= {4'b0, j.word, j.mode};
          s_axis_tvalid <= 1'b1;
          drv_gap <= gap_len();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    s_axis_tready_q <= s_axis_tready && s_axis_tvalid;
    if (s_axis_tvalid && s_axis_tready) begin
      resp_expected.push_back(list_step(s_axis_tdata[3:0], s_axis_tdata[35:4]));
      n_sent++;
    end
  end

  // monitor
  int rdy_gap = 0;
  always @(negedge clk_i) begin
    if (rdy_gap > 0) begin
      rdy_gap <= rdy_gap - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) rdy_gap <= gap_len();
    end
  end

  always @(posedge clk_i) begin
    resp_t got, exp_r;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[39:0];
      n_seen++;
      if (resp_expected.size() == 0) begin
        $error("unexpected result transaction %h", m_axis_tdata);
        n_fail++;
      end else begin
        exp_r = resp_expected.pop_front();
        if (got.ok !== exp_r.ok) begin
          $error("ok expected %0d got %0d", exp_r.ok, got.ok); n_fail++;
        end
        if (got.job_out !== exp_r.job_out) begin
          $error("job_out expected %h got %h", exp_r.job_out, got.job_out); n_fail++;
        end
        if (got.entry_count !== exp_r.entry_count) begin
          $error("entry_count expected %0d got %0d", exp_r.entry_count,
                 got.entry_count); n_fail++;
        end
        if (got.is_full !== exp_r.is_full) begin
          $error("is_full expected %0d got %0d", exp_r.is_full, got.is_full); n_fail++;
        end
        if (got.is_empty !== exp_r.is_empty) begin
          $error("is_empty expected %0d got %0d", exp_r.is_empty, got.is_empty);
          n_fail++;
        end
      end
    end
  end

  task automatic push_job(logic [3:0] mode, logic [31:0] word);
    job_req_t j;
    j.mode = mode; j.word = word;
    job_pending.push_back(j);
  endtask

  task automatic drain();
    while (job_pending.size() > 0 || s_axis_tvalid || resp_expected.size() > 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [4:0] v);
    @(negedge clk_i);
    cfg_wdata_i <= v;
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sh_cap = v;
  endtask

  // random phase: appends, the other list modes and some unused modes at random
  task automatic random_phase(int n);
    int p;
    logic [3:0] m;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 99);
      if (p < 30) m = cljq_pkg::MODE_APPEND;
      else if (p < 95) m = 4'($urandom_range(1, 8));
      else m = 4'($urandom_range(9, 15));
      push_job(m, $urandom());
    end
  endtask

  initial begin
    logic [4:0] caps [6] = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd5, 5'd9};
    for (int i = 0; i < cljq_pkg::SlotN; i++) sh_free[i] = 4'(cljq_pkg::SlotN - 1 - i);
    sh_ftop = cljq_pkg::SlotN; sh_head = 0; sh_tail = 0; sh_cur = 0; sh_cnt = 0;
    sh_cap = 1;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    repeat (20) @(posedge clk_i);
    // directed: empty refusals, capacity one, walk, unused modes
    for (int m = cljq_pkg::MODE_REMOVE; m <= cljq_pkg::MODE_WRITE; m++)
      push_job(4'(m), 32'hFFFF_FFFF);
    push_job(cljq_pkg::MODE_APPEND, 32'h0000_0000);
    push_job(cljq_pkg::MODE_APPEND, 32'hFFFF_FFFF);
    push_job(cljq_pkg::MODE_READ, 0);
    push_job(4'd9, 0);
    push_job(4'd15, 32'hFFFF_FFFF);
    drain();
    set_capacity(5'd3);
    push_job(cljq_pkg::MODE_APPEND, 32'hA5A5_A5A5);
    push_job(cljq_pkg::MODE_APPEND, 32'h5A5A_5A5A);
    push_job(cljq_pkg::MODE_APPEND, 32'h1234_5678);
    for (int m = cljq_pkg::MODE_NEXT; m <= cljq_pkg::MODE_WRITE; m++)
      push_job(4'(m), 32'hDEAD_BEEF);
    push_job(cljq_pkg::MODE_READ, 0);
    push_job(cljq_pkg::MODE_DELETE, 0);
    push_job(cljq_pkg::MODE_REMOVE, 0);
    drain();
    // lowered to the count
    set_capacity(5'd1);
    push_job(cljq_pkg::MODE_APPEND, 32'h1);
    push_job(cljq_pkg::MODE_READ, 0);
    drain();
    for (int k = 0; k < 6; k++) begin
      set_capacity(caps[k]);
      random_phase(180);
      drain();
    end
    $display("covered %0d operation transactions, %0d results, capacities 0 to 31",
             n_sent, n_seen);
    if (n_fail == 0) $display("tb_cursor_linked_job_queue OK");
    else $display("tb_cursor_linked_job_queue NOT OK");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_cursor_linked_job_queue NOT OK");
    $finish;
  end
endmodule

>>> files.f
rtl/cljq_pkg.sv
rtl/cljq_datapath.sv
rtl/cljq_ctrl.sv
rtl/cursor_linked_job_queue.sv
rtl/cljq_checker.sv
sim/tb_cursor_linked_job_queue.sv
